@@ hw/rtl/sgpg_pkg.sv @@
// Shared types and constants of the spherical grid point generator.
// Depends on nothing; used by every module of the block.
package sgpg_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INCL_START   = 3'd0,
        REG_INCL_END     = 3'd1,
        REG_INCL_STEP    = 3'd2,
        REG_AZIM_START   = 3'd3,
        REG_AZIM_END     = 3'd4,
        REG_AZIM_STEP    = 3'd5,
        REG_RADIUS_START = 3'd6,
        REG_RADIUS_STEP  = 3'd7
    } reg_idx_t;

    localparam logic signed [19:0] INCL_START_RST   = -20'sd17157;
    localparam logic signed [19:0] INCL_END_RST     = 20'sd17157;
    localparam logic        [18:0] INCL_STEP_RST    = 19'd2288;
    localparam logic signed [19:0] AZIM_START_RST   = 20'sd0;
    localparam logic signed [19:0] AZIM_END_RST     = 20'sd411775;
    localparam logic        [18:0] AZIM_STEP_RST    = 19'd229;
    localparam logic        [31:0] RADIUS_START_RST = 32'd32768;
    localparam logic        [19:0] RADIUS_STEP_RST  = 20'd655;

    // Angles in Q.30 radians.
    localparam logic signed [37:0] Q30_HALF_PI  = 38'sd1686629713;
    localparam logic signed [37:0] Q30_PI       = 38'sd3373259426;
    localparam logic signed [37:0] Q30_TWO_PI   = 38'sd6746518852;
    localparam logic signed [33:0] Q30_INV_GAIN = 34'sd652032874;
    localparam logic signed [31:0] Q30_ROUND    = 32'sd536870912;

    // One point job handed from the sweep front end to the arithmetic back end.
    typedef struct packed {
        logic               point_valid;
        logic               sweep_last;
        logic signed [20:0] incl;
        logic signed [21:0] azim;
        logic        [31:0] radius;
    } job_t;

    // CORDIC working set: cosine and sine accumulators and residual angle.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [37:0] z;
    } cordic_t;

    // Arctangent of 2^-i in Q.30, rounded to nearest, for i up to 23; zero above.
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/spherical_grid_point_generator_core.sv @@
// Top level of the spherical grid point generator: lidar-style test points.
// Depends on sgpg_pkg, sgpg_front, sgpg_queue and sgpg_back.
//
//   channel   handshake         payload
//   input     push / full       restart
//   result    empty / pop       pos_x, pos_y, pos_z, point_valid, sweep_last
//   config    cfg_valid / ready cfg_index, cfg_data
//
// The front end takes an item whenever the two-entry job queue has room; the
// back end takes one job at a time from the queue: it reduces both angles by
// turns of 2*pi, runs the CORDIC rotations and the radius products, and sends
// an empty-grid item straight to its done state. Reset loads the default
// registers and puts the sweep at its first point. An unpopped result stalls
// only the back end; the front end keeps taking items until the queue fills.
module spherical_grid_point_generator_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               restart,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               point_valid,
    output logic               sweep_last
);

    logic           job_wr, q_full, q_rd, q_empty;
    sgpg_pkg::job_t job_in, job_out;

    assign full = q_full;

    sgpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .restart   (restart),
        .q_full    (q_full),
        .job_wr    (job_wr),
        .job       (job_in)
    );

    sgpg_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    sgpg_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (job_out),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_valid (point_valid),
        .sweep_last  (sweep_last)
    );

endmodule

@@ hw/rtl/sgpg_front.sv @@
// Front end: configuration registers and the azimuth-by-inclination sweep
// counters; turns each accepted item into a point job. Uses sgpg_pkg.
module sgpg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              push,
    input  logic              restart,
    input  logic              q_full,
    output logic              job_wr,
    output sgpg_pkg::job_t    job
);

    logic signed [19:0] incl_start_reg, incl_end_reg, azim_start_reg, azim_end_reg;
    logic        [18:0] incl_step_reg, azim_step_reg;
    logic        [31:0] radius_start_reg;
    logic        [19:0] radius_step_reg;

    logic signed [20:0] incl_now_reg, incl_now_next;
    logic signed [21:0] azim_now_reg, azim_now_next;
    logic        [31:0] radius_now_reg, radius_now_next;

    logic signed [23:0] istep_s, astep_s, incl_bound, azim_bound;
    logic signed [23:0] incl_inc, azim_inc;
    logic signed [20:0] incl_cur;
    logic signed [21:0] azim_cur;
    logic        [31:0] radius_cur;
    logic        [32:0] radius_sum;
    logic               start_empty, stale, use_start, incl_wrap, azim_wrap, accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign job_wr    = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incl_start_reg   <= sgpg_pkg::INCL_START_RST;
            incl_end_reg     <= sgpg_pkg::INCL_END_RST;
            incl_step_reg    <= sgpg_pkg::INCL_STEP_RST;
            azim_start_reg   <= sgpg_pkg::AZIM_START_RST;
            azim_end_reg     <= sgpg_pkg::AZIM_END_RST;
            azim_step_reg    <= sgpg_pkg::AZIM_STEP_RST;
            radius_start_reg <= sgpg_pkg::RADIUS_START_RST;
            radius_step_reg  <= sgpg_pkg::RADIUS_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (sgpg_pkg::reg_idx_t'(cfg_index))
                sgpg_pkg::REG_INCL_START:   incl_start_reg   <= $signed(cfg_data[19:0]);
                sgpg_pkg::REG_INCL_END:     incl_end_reg     <= $signed(cfg_data[19:0]);
                sgpg_pkg::REG_INCL_STEP:    incl_step_reg    <= cfg_data[18:0];
                sgpg_pkg::REG_AZIM_START:   azim_start_reg   <= $signed(cfg_data[19:0]);
                sgpg_pkg::REG_AZIM_END:     azim_end_reg     <= $signed(cfg_data[19:0]);
                sgpg_pkg::REG_AZIM_STEP:    azim_step_reg    <= cfg_data[18:0];
                sgpg_pkg::REG_RADIUS_START: radius_start_reg <= cfg_data;
                sgpg_pkg::REG_RADIUS_STEP:  radius_step_reg  <= cfg_data[19:0];
                default:                    incl_step_reg    <= incl_step_reg;
            endcase
        end
    end

    always_comb
    begin
        istep_s    = $signed(24'(incl_step_reg));
        astep_s    = $signed(24'(azim_step_reg));
        incl_bound = 24'(incl_end_reg) + istep_s;
        azim_bound = 24'(azim_end_reg) + (astep_s <<< 1);

        start_empty = (24'(incl_start_reg) >= incl_bound) ||
                      (24'(azim_start_reg) >= azim_bound);
        // A register write may leave the running position past its bound.
        stale       = (24'(incl_now_reg) >= incl_bound) ||
                      (24'(azim_now_reg) >= azim_bound);
        use_start   = restart || stale;

        incl_cur   = use_start ? 21'(incl_start_reg) : incl_now_reg;
        azim_cur   = use_start ? 22'(azim_start_reg) : azim_now_reg;
        radius_cur = use_start ? radius_start_reg : radius_now_reg;

        incl_inc   = 24'(incl_cur) + istep_s;
        azim_inc   = 24'(azim_cur) + astep_s;
        incl_wrap  = !(incl_inc < incl_bound);
        azim_wrap  = !(azim_inc < azim_bound);
        radius_sum = {1'b0, radius_cur} + 33'(radius_step_reg);

        job.point_valid = !start_empty;
        job.sweep_last  = 1'b0;
        job.incl        = incl_cur;
        job.azim        = azim_cur;
        job.radius      = radius_cur;

        incl_now_next   = incl_now_reg;
        azim_now_next   = azim_now_reg;
        radius_now_next = radius_now_reg;

        if (start_empty)
        begin
            if (restart)
            begin
                incl_now_next   = 21'(incl_start_reg);
                azim_now_next   = 22'(azim_start_reg);
                radius_now_next = radius_start_reg;
            end
        end
        else if (!incl_wrap)
        begin
            incl_now_next   = 21'(incl_inc);
            azim_now_next   = azim_cur;
            radius_now_next = radius_cur;
        end
        else
        begin
            incl_now_next = 21'(incl_start_reg);
            if (!azim_wrap)
            begin
                azim_now_next   = 22'(azim_inc);
                radius_now_next = radius_sum[32] ? 32'hFFFF_FFFF : radius_sum[31:0];
            end
            else
            begin
                // End of the sweep: back to the first grid point.
                azim_now_next   = 22'(azim_start_reg);
                radius_now_next = radius_start_reg;
                job.sweep_last  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incl_now_reg   <= 21'(sgpg_pkg::INCL_START_RST);
            azim_now_reg   <= 22'(sgpg_pkg::AZIM_START_RST);
            radius_now_reg <= sgpg_pkg::RADIUS_START_RST;
        end
        else if (accept)
        begin
            incl_now_reg   <= incl_now_next;
            azim_now_reg   <= azim_now_next;
            radius_now_reg <= radius_now_next;
        end
    end

endmodule

@@ hw/rtl/sgpg_queue.sv @@
// Short job queue between the sweep front end and the arithmetic back end.
// Holds sgpg_pkg::job_t entries in registers.
module sgpg_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sgpg_pkg::job_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output sgpg_pkg::job_t rd_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgpg_pkg::job_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue holds more items than its depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("job written into a full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("job read from an empty queue");

endmodule

@@ hw/rtl/sgpg_back.sv @@
// Back end: angle reduction, two iterative CORDIC rotations, the radius
// products and the result register. Uses sgpg_pkg.
module sgpg_back #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sgpg_pkg::job_t     q_job,
    output logic               q_rd,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               point_valid,
    output logic               sweep_last
);

    localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_ITER = 6'b000100,
        S_MUL1 = 6'b001000,
        S_MUL2 = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    sgpg_pkg::cordic_t   ci_reg, ci_next, ca_reg, ca_next;
    logic                negi_reg, negi_next, nega_reg, nega_next;
    logic [31:0]         r_reg, r_next;
    logic                pv_reg, pv_next, last_reg, last_next;
    logic signed [66:0]  pc_reg, pc_next, ps_reg, ps_next;
    logic signed [37:0]  rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;

    logic                out_valid_reg, out_valid_next, out_load;
    logic signed [31:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic                point_valid_reg, sweep_last_reg;

    logic signed [37:0]  zi_w, za_w;
    logic                in_range;
    logic signed [33:0]  trig_c, trig_s, rc;
    logic signed [32:0]  r_s;
    logic signed [67:0]  px, py;

    function automatic logic signed [37:0] wrap_2pi(input logic signed [37:0] z);
        logic signed [37:0] v;
        v = z;
        if (z > sgpg_pkg::Q30_PI)
        begin
            v = z - sgpg_pkg::Q30_TWO_PI;
        end
        else if (z < -sgpg_pkg::Q30_PI)
        begin
            v = z + sgpg_pkg::Q30_TWO_PI;
        end
        return v;
    endfunction

    // Folds into [-pi/2, pi/2] and seeds the rotation; neg marks a half turn.
    function automatic sgpg_pkg::cordic_t seed(input logic signed [37:0] z,
                                               output logic neg);
        sgpg_pkg::cordic_t c;
        c.x = sgpg_pkg::Q30_INV_GAIN;
        c.y = '0;
        c.z = z;
        neg = 1'b0;
        if (z > sgpg_pkg::Q30_HALF_PI)
        begin
            c.z = z - sgpg_pkg::Q30_PI;
            neg = 1'b1;
        end
        else if (z < -sgpg_pkg::Q30_HALF_PI)
        begin
            c.z = z + sgpg_pkg::Q30_PI;
            neg = 1'b1;
        end
        return c;
    endfunction

    function automatic sgpg_pkg::cordic_t rotate(input sgpg_pkg::cordic_t a,
                                                 input logic [CNT_W-1:0] i);
        sgpg_pkg::cordic_t  c;
        logic signed [33:0] sx, sy;
        logic signed [37:0] at;
        sx = a.x >>> i;
        sy = a.y >>> i;
        at = $signed({8'b0, sgpg_pkg::atan_q30(5'(i))});
        if (a.z >= 0)
        begin
            c.x = a.x - sy;
            c.y = a.y + sx;
            c.z = a.z - at;
        end
        else
        begin
            c.x = a.x + sy;
            c.y = a.y - sx;
            c.z = a.z + at;
        end
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] s;
        if (v > 38'sd2147483647)
        begin
            s = 32'sh7FFF_FFFF;
        end
        else if (v < -38'sd2147483648)
        begin
            s = 32'sh8000_0000;
        end
        else
        begin
            s = v[31:0];
        end
        return s;
    endfunction

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || pop);
    assign q_rd     = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ci_next    = ci_reg;
        ca_next    = ca_reg;
        negi_next  = negi_reg;
        nega_next  = nega_reg;
        r_next     = r_reg;
        pv_next    = pv_reg;
        last_next  = last_reg;
        pc_next    = pc_reg;
        ps_next    = ps_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rz_next    = rz_reg;

        zi_w     = wrap_2pi(ci_reg.z);
        za_w     = wrap_2pi(ca_reg.z);
        in_range = (zi_w == ci_reg.z) && (za_w == ca_reg.z);

        trig_c = negi_reg ? -ci_reg.x : ci_reg.x;
        trig_s = negi_reg ? -ci_reg.y : ci_reg.y;
        r_s    = $signed({1'b0, r_reg});
        rc     = $signed(pc_reg[63:30]);
        px     = rc * ca_reg.x + sgpg_pkg::Q30_ROUND;
        py     = rc * ca_reg.y + sgpg_pkg::Q30_ROUND;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    ci_next.z = 38'($signed({q_job.incl, 14'b0}));
                    ca_next.z = 38'($signed({q_job.azim, 14'b0}));
                    r_next    = q_job.radius;
                    pv_next   = q_job.point_valid;
                    last_next = q_job.sweep_last;
                    if (q_job.point_valid)
                    begin
                        state_next = S_RED;
                    end
                    else
                    begin
                        // Empty grid: an all-zero point.
                        rx_next    = '0;
                        ry_next    = '0;
                        rz_next    = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_RED:
            begin
                // One turn of 2*pi off each angle per cycle until both lie
                // within a half turn, then fold and start rotating.
                if (in_range)
                begin
                    ci_next    = seed(ci_reg.z, negi_next);
                    ca_next    = seed(ca_reg.z, nega_next);
                    cnt_next   = '0;
                    state_next = S_ITER;
                end
                else
                begin
                    ci_next.z = zi_w;
                    ca_next.z = za_w;
                end
            end
            S_ITER:
            begin
                ci_next  = rotate(ci_reg, cnt_reg);
                ca_next  = rotate(ca_reg, cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                pc_next   = r_s * trig_c + sgpg_pkg::Q30_ROUND;
                ps_next   = r_s * trig_s + sgpg_pkg::Q30_ROUND;
                ca_next.x = nega_reg ? -ca_reg.x : ca_reg.x;
                ca_next.y = nega_reg ? -ca_reg.y : ca_reg.y;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                rx_next    = $signed(px[67:30]);
                ry_next    = $signed(py[67:30]);
                rz_next    = 38'($signed(ps_reg[63:30]));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg   <= ci_next;
        ca_reg   <= ca_next;
        negi_reg <= negi_next;
        nega_reg <= nega_next;
        r_reg    <= r_next;
        pv_reg   <= pv_next;
        last_reg <= last_next;
        pc_reg   <= pc_next;
        ps_reg   <= ps_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= rz_next;
        if (out_load)
        begin
            pos_x_reg       <= sat32(rx_reg);
            pos_y_reg       <= sat32(ry_reg);
            pos_z_reg       <= sat32(rz_reg);
            point_valid_reg <= pv_reg;
            sweep_last_reg  <= last_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign point_valid = point_valid_reg;
    assign sweep_last  = sweep_last_reg;

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) |-> (cnt_reg <= CNT_W'(CORDIC_ITERATIONS - 1)))
        else $error("rotation counter ran past the last iteration");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && !pop |=> (state_reg == S_DONE))
        else $error("finished point dropped while the result register was occupied");

endmodule
